// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the timer block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ptc_pkg.sv =====
// ----------------------------------------------------------------------------
// ptc_pkg
// Types, codes and pin-action functions shared by the timer modules.
// ----------------------------------------------------------------------------
package ptc_pkg;

  localparam int NOISE_SAMPLES_DEF = 4;

  // Transaction kinds on the input channel.
  localparam logic [1:0] KIND_TICK     = 2'd0;
  localparam logic [1:0] KIND_WR_COUNT = 2'd1;
  localparam logic [1:0] KIND_WR_CAPT  = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_WAVE_MODE    = 3'd0;
  localparam logic [2:0] REG_CLOCK_SEL    = 3'd1;
  localparam logic [2:0] REG_OUTPUT_MODES = 3'd2;
  localparam logic [2:0] REG_COMPARE_A    = 3'd3;
  localparam logic [2:0] REG_COMPARE_B    = 3'd4;
  localparam logic [2:0] REG_COMPARE_C    = 3'd5;
  localparam logic [2:0] REG_NOISE_CANCEL = 3'd6;
  localparam logic [2:0] REG_CAPTURE_EDGE = 3'd7;

  // Clock source selection.
  localparam logic [2:0] CS_STOP     = 3'd0;
  localparam logic [2:0] CS_DIV1     = 3'd1;
  localparam logic [2:0] CS_DIV8     = 3'd2;
  localparam logic [2:0] CS_DIV64    = 3'd3;
  localparam logic [2:0] CS_DIV256   = 3'd4;
  localparam logic [2:0] CS_DIV1024  = 3'd5;
  localparam logic [2:0] CS_EXT_FALL = 3'd6;
  localparam logic [2:0] CS_EXT_RISE = 3'd7;

  // Compare output modes.
  localparam logic [1:0] OM_OFF    = 2'd0;
  localparam logic [1:0] OM_TOGGLE = 2'd1;
  localparam logic [1:0] OM_CLEAR  = 2'd2;
  localparam logic [1:0] OM_SET    = 2'd3;

  // Waveform modes named individually.
  localparam logic [3:0] WM_NORMAL      = 4'd0;
  localparam logic [3:0] WM_PC8         = 4'd1;
  localparam logic [3:0] WM_PC9         = 4'd2;
  localparam logic [3:0] WM_PC10        = 4'd3;
  localparam logic [3:0] WM_CTC_OCRA    = 4'd4;
  localparam logic [3:0] WM_FAST8       = 4'd5;
  localparam logic [3:0] WM_FAST9       = 4'd6;
  localparam logic [3:0] WM_FAST10      = 4'd7;
  localparam logic [3:0] WM_PFC_ICR     = 4'd8;
  localparam logic [3:0] WM_PFC_OCRA    = 4'd9;
  localparam logic [3:0] WM_PC_ICR      = 4'd10;
  localparam logic [3:0] WM_PC_OCRA     = 4'd11;
  localparam logic [3:0] WM_CTC_ICR     = 4'd12;
  localparam logic [3:0] WM_ILLEGAL     = 4'd13;
  localparam logic [3:0] WM_FAST_ICR    = 4'd14;
  localparam logic [3:0] WM_FAST_OCRA   = 4'd15;

  typedef struct packed {
    logic [3:0]  wave_mode;
    logic [2:0]  clock_select;
    logic [5:0]  output_modes;
    logic [15:0] compare_a;
    logic [15:0] compare_b;
    logic [15:0] compare_c;
    logic        noise_cancel;
    logic        capture_edge;
  } ptc_cfg_t;

  typedef struct packed {
    logic [15:0] counter;
    logic        dir_up;
    logic [2:0]  pins;       // bit 0 is channel A, bit 2 channel C
    logic [15:0] capture;
    logic        ext_prev;
    logic        cap_prev;
    logic [2:0]  noise_count;
  } ptc_state_t;

  // Capture-pin filter update handed from the filter to the counter logic.
  typedef struct packed {
    logic       cap_prev;
    logic [2:0] noise_count;
    logic       take;
  } ptc_cap_upd_t;

  typedef struct packed {
    logic [15:0] count_value;
    logic        counting_up;
    logic        wave_a;
    logic        wave_b;
    logic        wave_c;
    logic        overflow_hit;
    logic        match_a_hit;
    logic        match_b_hit;
    logic        match_c_hit;
    logic        capture_hit;
    logic [15:0] captured_value;
    logic        illegal_mode;
  } ptc_result_t;

  function automatic logic is_dual(input logic [3:0] m);
    return (m >= WM_PC8 && m <= WM_PC10) || (m >= WM_PFC_ICR && m <= WM_PC_OCRA);
  endfunction

  function automatic logic is_fast(input logic [3:0] m);
    return (m >= WM_FAST8 && m <= WM_FAST10) || m == WM_FAST_ICR || m == WM_FAST_OCRA;
  endfunction

  function automatic logic is_single(input logic [3:0] m);
    return m == WM_NORMAL || m == WM_CTC_OCRA || m == WM_CTC_ICR;
  endfunction

  function automatic logic [15:0] top_value(input logic [3:0]  m,
                                            input logic [15:0] cmp_a,
                                            input logic [15:0] cap);
    logic [15:0] t;
    unique case (m)
      WM_PC8, WM_FAST8:                               t = 16'h00FF;
      WM_PC9, WM_FAST9:                               t = 16'h01FF;
      WM_PC10, WM_FAST10:                             t = 16'h03FF;
      WM_CTC_OCRA, WM_PFC_OCRA, WM_PC_OCRA, WM_FAST_OCRA: t = cmp_a;
      WM_PFC_ICR, WM_PC_ICR, WM_CTC_ICR, WM_FAST_ICR: t = cap;
      default:                                        t = 16'hFFFF;
    endcase
    return t;
  endfunction

  // Pin level after a compare match.
  function automatic logic match_pin(input logic [3:0] m, input logic [1:0] om,
                                     input logic dir_up, input logic pin);
    logic p;
    p = pin;
    if (is_single(m)) begin
      unique case (om)
        OM_TOGGLE: p = ~pin;
        OM_CLEAR:  p = 1'b0;
        OM_SET:    p = 1'b1;
        default:   p = pin;
      endcase
    end else if (is_dual(m)) begin
      unique case (om)
        OM_TOGGLE: p = (m >= WM_PFC_ICR) ? ~pin : pin;
        OM_CLEAR:  p = ~dir_up;
        OM_SET:    p = dir_up;
        default:   p = pin;
      endcase
    end else if (is_fast(m)) begin
      unique case (om)
        OM_TOGGLE: p = (m >= WM_PFC_ICR) ? ~pin : pin;
        OM_CLEAR:  p = 1'b0;
        OM_SET:    p = 1'b1;
        default:   p = pin;
      endcase
    end
    return p;
  endfunction

  // Pin level when a fast PWM period restarts at top.
  function automatic logic top_pin(input logic [3:0] m, input logic [1:0] om,
                                   input logic pin);
    logic p;
    unique case (om)
      OM_TOGGLE: p = (m >= WM_PFC_ICR) ? ~pin : pin;
      OM_CLEAR:  p = 1'b1;
      OM_SET:    p = 1'b0;
      default:   p = pin;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/core/pwm_timer_16bit_three_compare_capture.sv =====
// ----------------------------------------------------------------------------
// pwm_timer_16bit_three_compare_capture
// 16-bit timer/counter with three compare outputs and input capture.
// ----------------------------------------------------------------------------
// Usage
// Each input transaction is one timer tick, a counter write or a capture
// register write, selected by in_mode. The block returns exactly one result
// transaction per input transaction, carrying the counter, direction, the
// three compare pin levels, the event pulses and the capture register.
// Configuration is written on the cfg_ channel, one register per transaction
// addressed by cfg_index; the user must see that it is only changed while the
// timer is idle, as the block itself does not enforce this. The result of each
// accepted transaction is registered in the output register, or in the skid
// register while the receiver stalls. Throughput is one transaction per cycle
// while in_ready is high; the update is one pass of combinational logic.
// A two-entry result buffer (output plus skid register) keeps input flowing
// for one extra transaction while the receiver stalls; in_ready falls only
// when both entries hold results. Reset clears the timer state to zero with
// the count direction up, clears all configuration, and empties the buffer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pwm_timer_16bit_three_compare_capture
  import ptc_pkg::*;
#(
  parameter int NOISE_SAMPLES = NOISE_SAMPLES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,

  // Input channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [9:0]  in_prescale_count,
  input  logic        in_ext_clock_pin,
  input  logic        in_capture_pin,
  input  logic [15:0] in_write_value,

  // Result channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_count_value,
  output logic        out_counting_up,
  output logic        out_wave_a,
  output logic        out_wave_b,
  output logic        out_wave_c,
  output logic        out_overflow_hit,
  output logic        out_match_a_hit,
  output logic        out_match_b_hit,
  output logic        out_match_c_hit,
  output logic        out_capture_hit,
  output logic [15:0] out_captured_value,
  output logic        out_illegal_mode
);

  // After reset the timer sits at zero, counting upward, with every pin low.
  localparam ptc_state_t STATE_RESET = '{counter: 16'd0, dir_up: 1'b1, pins: 3'd0,
                                         capture: 16'd0, ext_prev: 1'b0,
                                         cap_prev: 1'b0, noise_count: 3'd0};

  ptc_cfg_t    cfg_r, cfg_nxt;
  ptc_state_t  state_r;
  ptc_state_t  state_nxt;
  ptc_result_t step_res;
  ptc_result_t out_res;
  logic        in_fire;

  // Register writes are always taken at once.
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_WAVE_MODE:    cfg_nxt.wave_mode    = cfg_data[3:0];
        REG_CLOCK_SEL:    cfg_nxt.clock_select = cfg_data[2:0];
        REG_OUTPUT_MODES: cfg_nxt.output_modes = cfg_data[5:0];
        REG_COMPARE_A:    cfg_nxt.compare_a    = cfg_data;
        REG_COMPARE_B:    cfg_nxt.compare_b    = cfg_data;
        REG_COMPARE_C:    cfg_nxt.compare_c    = cfg_data;
        REG_NOISE_CANCEL: cfg_nxt.noise_cancel = cfg_data[0];
        REG_CAPTURE_EDGE: cfg_nxt.capture_edge = cfg_data[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The complete per-transaction update is computed combinationally from the
  // state registers and the presented input fields.
  ptc_core #(
    .NOISE_SAMPLES (NOISE_SAMPLES)
  ) u_core (
    .cfg            (cfg_r),
    .cur            (state_r),
    .kind           (in_mode),
    .prescale_count (in_prescale_count),
    .ext_clock_pin  (in_ext_clock_pin),
    .capture_pin    (in_capture_pin),
    .write_value    (in_write_value),
    .nxt            (state_nxt),
    .res            (step_res)
  );

  // The timer state moves only when a transaction is accepted, so a stall on
  // either side freezes the count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  ptc_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_data (step_res),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_res)
  );

  assign out_count_value    = out_res.count_value;
  assign out_counting_up    = out_res.counting_up;
  assign out_wave_a         = out_res.wave_a;
  assign out_wave_b         = out_res.wave_b;
  assign out_wave_c         = out_res.wave_c;
  assign out_overflow_hit   = out_res.overflow_hit;
  assign out_match_a_hit    = out_res.match_a_hit;
  assign out_match_b_hit    = out_res.match_b_hit;
  assign out_match_c_hit    = out_res.match_c_hit;
  assign out_capture_hit    = out_res.capture_hit;
  assign out_captured_value = out_res.captured_value;
  assign out_illegal_mode   = out_res.illegal_mode;

  // A full buffer always has a result on offer.
  `ASSERT_IMPLIES(a_full_has_output, clk, rst_n, !in_ready, out_valid, "buffer full without output")
  // Every accepted transaction leaves a result on offer at the next edge.
  `ASSERT_NEXT(a_accept_gives_result, clk, rst_n, in_fire, out_valid, "accepted item lost")
  // Accepting while the held result is stalled fills the skid entry.
  `ASSERT_NEXT(a_stall_fills_skid, clk, rst_n, in_fire && out_valid && !out_ready, !in_ready, "skid not filled")

endmodule

// ===== rtl/core/ptc_tick_gen.sv =====
// ----------------------------------------------------------------------------
// ptc_tick_gen
// Decides whether the counter advances on this tick.
// ----------------------------------------------------------------------------
module ptc_tick_gen
  import ptc_pkg::*;
(
  input  logic [2:0] clock_select,
  input  logic [9:0] prescale_count,
  input  logic       ext_pin,
  input  logic       ext_prev,
  output logic       fire
);

  always_comb begin
    unique case (clock_select)
      CS_STOP:     fire = 1'b0;
      CS_DIV1:     fire = 1'b1;
      CS_DIV8:     fire = (prescale_count[2:0] == 3'd0);
      CS_DIV64:    fire = (prescale_count[5:0] == 6'd0);
      CS_DIV256:   fire = (prescale_count[7:0] == 8'd0);
      CS_DIV1024:  fire = (prescale_count == 10'd0);
      CS_EXT_FALL: fire = ~ext_pin & ext_prev;
      CS_EXT_RISE: fire = ext_pin & ~ext_prev;
      default:     fire = 1'b0;
    endcase
  end

endmodule

// ===== rtl/core/ptc_capture.sv =====
// ----------------------------------------------------------------------------
// ptc_capture
// Capture-pin edge detection with the optional sample-count noise filter.
// ----------------------------------------------------------------------------
module ptc_capture
  import ptc_pkg::*;
#(
  parameter int NOISE_SAMPLES = NOISE_SAMPLES_DEF
) (
  input  logic         tick,
  input  logic         cap_pin,
  input  logic         cap_prev,
  input  logic [2:0]   noise_count,
  input  logic         noise_cancel,
  input  logic         capture_edge,
  output ptc_cap_upd_t upd
);

  logic [2:0] count_inc;

  assign count_inc = noise_count + 3'd1;

  always_comb begin
    upd.cap_prev    = cap_prev;
    upd.noise_count = noise_count;
    upd.take        = 1'b0;
    if (tick && (cap_pin != cap_prev)) begin
      // The count keeps running when the pin settles back; only acceptance clears it.
      if (!noise_cancel || (count_inc >= 3'(NOISE_SAMPLES))) begin
        upd.noise_count = 3'd0;
        upd.cap_prev    = cap_pin;
        upd.take        = (cap_pin == capture_edge);
      end else begin
        upd.noise_count = count_inc;
      end
    end
  end

endmodule

// ===== rtl/core/ptc_core.sv =====
// ----------------------------------------------------------------------------
// ptc_core
// Next-state and result logic for one transaction of the timer.
// ----------------------------------------------------------------------------
module ptc_core
  import ptc_pkg::*;
#(
  parameter int NOISE_SAMPLES = NOISE_SAMPLES_DEF
) (
  input  ptc_cfg_t    cfg,
  input  ptc_state_t  cur,
  input  logic [1:0]  kind,
  input  logic [9:0]  prescale_count,
  input  logic        ext_clock_pin,
  input  logic        capture_pin,
  input  logic [15:0] write_value,
  output ptc_state_t  nxt,
  output ptc_result_t res
);

  logic         is_tick;
  logic         fire;
  ptc_cap_upd_t cap_upd;
  logic [3:0]   m;
  logic         dual;
  logic         fast;
  logic [15:0]  top;
  logic [15:0]  cnt_step;
  logic [15:0]  ovf_point;
  logic [15:0]  cmp [3];
  logic [1:0]   om  [3];

  assign is_tick   = (kind == KIND_TICK);
  assign m         = cfg.wave_mode;
  assign dual      = is_dual(m);
  assign fast      = is_fast(m);
  assign top       = top_value(m, cfg.compare_a, cur.capture);
  assign cnt_step  = (dual && !cur.dir_up) ? cur.counter - 16'd1 : cur.counter + 16'd1;
  assign ovf_point = dual ? 16'h0000 : (fast ? top : 16'hFFFF);

  assign cmp[0] = cfg.compare_a;
  assign cmp[1] = cfg.compare_b;
  assign cmp[2] = cfg.compare_c;
  assign om[0]  = cfg.output_modes[5:4];
  assign om[1]  = cfg.output_modes[3:2];
  assign om[2]  = cfg.output_modes[1:0];

  ptc_tick_gen u_tick_gen (
    .clock_select   (cfg.clock_select),
    .prescale_count (prescale_count),
    .ext_pin        (ext_clock_pin),
    .ext_prev       (cur.ext_prev),
    .fire           (fire)
  );

  ptc_capture #(
    .NOISE_SAMPLES (NOISE_SAMPLES)
  ) u_capture (
    .tick         (is_tick),
    .cap_pin      (capture_pin),
    .cap_prev     (cur.cap_prev),
    .noise_count  (cur.noise_count),
    .noise_cancel (cfg.noise_cancel),
    .capture_edge (cfg.capture_edge),
    .upd          (cap_upd)
  );

  always_comb begin
    logic        ovf;
    logic [2:0]  hit;
    logic        cap_hit;
    nxt     = cur;
    ovf     = 1'b0;
    hit     = 3'b000;
    cap_hit = 1'b0;
    unique case (kind)
      KIND_WR_COUNT: nxt.counter = write_value;
      KIND_WR_CAPT:  nxt.capture = write_value;
      KIND_TICK: begin
        nxt.ext_prev = ext_clock_pin;
        if (fire) begin
          nxt.counter = cnt_step;
          ovf = (m != WM_ILLEGAL) && (cnt_step == ovf_point);
          for (int ch = 0; ch < 3; ch++) begin
            if (cnt_step == cmp[ch]) begin
              hit[ch]      = 1'b1;
              nxt.pins[ch] = match_pin(m, om[ch], cur.dir_up, cur.pins[ch]);
            end
          end
          if (is_single(m) || fast) begin
            if (cnt_step == top) begin
              nxt.counter = 16'd0;
              if (fast) begin
                for (int ch = 0; ch < 3; ch++) begin
                  nxt.pins[ch] = top_pin(m, om[ch], nxt.pins[ch]);
                end
              end
            end
          end else if (dual) begin
            if (!cur.dir_up) begin
              if (cnt_step == 16'd0) nxt.dir_up = 1'b1;
            end else if (cnt_step == top) begin
              nxt.dir_up = 1'b0;
            end
          end
          cap_hit = (nxt.counter == cur.capture) &&
                    (m == WM_PFC_ICR || m == WM_PC_ICR || m == WM_CTC_ICR ||
                     m == WM_FAST_ICR);
        end
        nxt.cap_prev    = cap_upd.cap_prev;
        nxt.noise_count = cap_upd.noise_count;
        if (cap_upd.take) begin
          nxt.capture = nxt.counter;
          cap_hit     = 1'b1;
        end
      end
      default: ;
    endcase

    res.count_value    = nxt.counter;
    res.counting_up    = nxt.dir_up;
    res.wave_a         = nxt.pins[0];
    res.wave_b         = nxt.pins[1];
    res.wave_c         = nxt.pins[2];
    res.overflow_hit   = ovf;
    res.match_a_hit    = hit[0];
    res.match_b_hit    = hit[1];
    res.match_c_hit    = hit[2];
    res.capture_hit    = cap_hit;
    res.captured_value = nxt.capture;
    res.illegal_mode   = (m == WM_ILLEGAL);
  end

endmodule

// ===== rtl/core/ptc_out_buf.sv =====
// ----------------------------------------------------------------------------
// ptc_out_buf
// Two-entry result buffer: an output register backed by a skid register.
// ----------------------------------------------------------------------------
module ptc_out_buf
  import ptc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  ptc_result_t push_data,
  output logic        can_push,
  output logic        out_valid,
  input  logic        out_ready,
  output ptc_result_t out_data
);

  logic        main_v_r, main_v_nxt;
  logic        skid_v_r, skid_v_nxt;
  ptc_result_t main_r, main_nxt;
  ptc_result_t skid_r, skid_nxt;
  logic        pop;

  assign pop       = main_v_r && out_ready;
  assign can_push  = ~skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_r;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (!main_v_r) begin
      if (push) begin
        main_nxt   = push_data;
        main_v_nxt = 1'b1;
      end
    end else if (pop) begin
      if (skid_v_r) begin
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end else if (push) begin
        main_nxt = push_data;
      end else begin
        main_v_nxt = 1'b0;
      end
    end else if (push) begin
      skid_nxt   = push_data;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Testbench for the 16-bit PWM timer with three compares and input capture
// Every tick, counter write and capture-register write is predicted by a
// cycle-free model of the timer held in a small scoreboard class, and each
// result transaction is compared field by field against the oldest
// prediction. The stimulus opens with two short directed sequences. It then
// runs through 24 configuration phases covering every waveform mode and
// clock source, with random flow control on both channels.
// ----------------------------------------------------------------------------
module tb;
  import ptc_pkg::*;

  // The fourth item kind has no meaning to the timer and must leave it alone.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam int PHASES          = 24;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int LONG_HOLD       = 300;

  // One input transaction, as offered on the in_ channel.
  typedef struct packed {
    logic [1:0]  kind;
    logic [9:0]  prescale;
    logic        ext_pin;
    logic        cap_pin;
    logic [15:0] value;
  } timer_item_t;

  // The scoreboard keeps its own copy of the configuration and of the timer
  // state, works out the result of every accepted input transaction and
  // queues it until the matching result transaction arrives.
  class timer_scoreboard;
    logic [3:0]  wmode;
    logic [2:0]  clk_sel;
    logic [5:0]  out_modes;
    logic [15:0] cmp [3];
    logic        nc_on;
    logic        cap_rise;

    logic [15:0] cnt;
    logic        up;
    logic [2:0]  pin;
    logic [15:0] icr;
    logic        ext_last;
    logic        icp_last;
    logic [2:0]  glitch_cnt;

    ptc_result_t due_results [$];
    int          errors;

    function new();
      wmode = WM_NORMAL;
      clk_sel = CS_STOP;
      out_modes = '0;
      for (int ch = 0; ch < 3; ch++) cmp[ch] = '0;
      nc_on = 1'b0;
      cap_rise = 1'b0;
      cnt = '0;
      up = 1'b1;
      pin = '0;
      icr = '0;
      ext_last = 1'b0;
      icp_last = 1'b0;
      glitch_cnt = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        REG_WAVE_MODE:    wmode = data[3:0];
        REG_CLOCK_SEL:    clk_sel = data[2:0];
        REG_OUTPUT_MODES: out_modes = data[5:0];
        REG_COMPARE_A:    cmp[0] = data;
        REG_COMPARE_B:    cmp[1] = data;
        REG_COMPARE_C:    cmp[2] = data;
        REG_NOISE_CANCEL: nc_on = data[0];
        REG_CAPTURE_EDGE: cap_rise = data[0];
        default: ;
      endcase
    endfunction

    function bit dual_slope();
      return (wmode >= WM_PC8 && wmode <= WM_PC10) ||
             (wmode >= WM_PFC_ICR && wmode <= WM_PC_OCRA);
    endfunction

    function bit fast_pwm();
      return (wmode >= WM_FAST8 && wmode <= WM_FAST10) ||
             wmode == WM_FAST_ICR || wmode == WM_FAST_OCRA;
    endfunction

    function bit single_slope();
      return wmode == WM_NORMAL || wmode == WM_CTC_OCRA || wmode == WM_CTC_ICR;
    endfunction

    function bit icr_is_top();
      return wmode == WM_PFC_ICR || wmode == WM_PC_ICR ||
             wmode == WM_CTC_ICR || wmode == WM_FAST_ICR;
    endfunction

    function logic [15:0] counter_top();
      case (wmode)
        WM_PC8, WM_FAST8:   return 16'h00FF;
        WM_PC9, WM_FAST9:   return 16'h01FF;
        WM_PC10, WM_FAST10: return 16'h03FF;
        WM_CTC_OCRA, WM_PFC_OCRA, WM_PC_OCRA, WM_FAST_OCRA: return cmp[0];
        WM_PFC_ICR, WM_PC_ICR, WM_CTC_ICR, WM_FAST_ICR:     return icr;
        default:            return 16'hFFFF;
      endcase
    endfunction

    // Channel A sits in the top two bits of the output mode register.
    function logic [1:0] chan_mode(int ch);
      return out_modes[5 - 2 * ch -: 2];
    endfunction

    // Applies the pin action of a compare match and reports whether it hit.
    function bit compare_match(int ch);
      logic [1:0] om;
      om = chan_mode(ch);
      if (cnt != cmp[ch]) return 1'b0;
      if (single_slope()) begin
        case (om)
          OM_TOGGLE: pin[ch] = ~pin[ch];
          OM_CLEAR:  pin[ch] = 1'b0;
          OM_SET:    pin[ch] = 1'b1;
          default: ;
        endcase
      end else if (dual_slope() || fast_pwm()) begin
        case (om)
          OM_TOGGLE: if (wmode >= WM_PFC_ICR) pin[ch] = ~pin[ch];
          OM_CLEAR:  pin[ch] = dual_slope() ? ~up : 1'b0;
          OM_SET:    pin[ch] = dual_slope() ? up : 1'b1;
          default: ;
        endcase
      end
      return 1'b1;
    endfunction

    // Pin action when a fast PWM period starts again from zero.
    function void restart_pin(int ch);
      case (chan_mode(ch))
        OM_TOGGLE: if (wmode >= WM_PFC_ICR) pin[ch] = ~pin[ch];
        OM_CLEAR:  pin[ch] = 1'b1;
        OM_SET:    pin[ch] = 1'b0;
        default: ;
      endcase
    endfunction

    function void advance_timer(timer_item_t it);
      ptc_result_t r;
      logic [15:0] period_top;
      logic [15:0] ovf_point;
      logic        fire;
      r = '0;
      fire = 1'b0;
      case (it.kind)
        KIND_WR_COUNT: cnt = it.value;
        KIND_WR_CAPT:  icr = it.value;
        KIND_TICK: begin
          case (clk_sel)
            CS_DIV1:     fire = 1'b1;
            CS_DIV8:     fire = it.prescale[2:0] == '0;
            CS_DIV64:    fire = it.prescale[5:0] == '0;
            CS_DIV256:   fire = it.prescale[7:0] == '0;
            CS_DIV1024:  fire = it.prescale == '0;
            CS_EXT_FALL: fire = !it.ext_pin && ext_last;
            CS_EXT_RISE: fire = it.ext_pin && !ext_last;
            default:     fire = 1'b0;
          endcase
          ext_last = it.ext_pin;

          if (fire) begin
            period_top = counter_top();
            if (dual_slope() && !up) cnt = cnt - 16'd1;
            else cnt = cnt + 16'd1;
            if (wmode != WM_ILLEGAL) begin
              ovf_point = dual_slope() ? 16'h0000 : (fast_pwm() ? period_top : 16'hFFFF);
              r.overflow_hit = cnt == ovf_point;
            end
            r.match_a_hit = compare_match(0);
            r.match_b_hit = compare_match(1);
            r.match_c_hit = compare_match(2);
            if (single_slope() || fast_pwm()) begin
              if (cnt == period_top) begin
                cnt = '0;
                if (fast_pwm()) for (int ch = 0; ch < 3; ch++) restart_pin(ch);
              end
            end else if (dual_slope()) begin
              if (!up) begin
                if (cnt == '0) up = 1'b1;
              end else if (cnt == period_top) begin
                up = 1'b0;
              end
            end
            r.capture_hit = (cnt == icr) && icr_is_top();
          end

          // The capture filter runs on every tick, clocked or not.
          if (it.cap_pin != icp_last) begin
            glitch_cnt = glitch_cnt + 3'd1;
            if (!nc_on || glitch_cnt >= NOISE_SAMPLES_DEF) begin
              glitch_cnt = '0;
              icp_last = it.cap_pin;
              if (it.cap_pin == cap_rise) begin
                icr = cnt;
                r.capture_hit = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
      r.count_value = cnt;
      r.counting_up = up;
      r.wave_a = pin[0];
      r.wave_b = pin[1];
      r.wave_c = pin[2];
      r.captured_value = icr;
      r.illegal_mode = wmode == WM_ILLEGAL;
      due_results.push_back(r);
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %h, got %h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(ptc_result_t got);
      ptc_result_t want;
      if (due_results.size() == 0) begin
        $error("result transaction arrived with nothing outstanding");
        errors++;
        return;
      end
      want = due_results.pop_front();
      check_field("count_value", want.count_value, got.count_value);
      check_field("counting_up", want.counting_up, got.counting_up);
      check_field("wave_a", want.wave_a, got.wave_a);
      check_field("wave_b", want.wave_b, got.wave_b);
      check_field("wave_c", want.wave_c, got.wave_c);
      check_field("overflow_hit", want.overflow_hit, got.overflow_hit);
      check_field("match_a_hit", want.match_a_hit, got.match_a_hit);
      check_field("match_b_hit", want.match_b_hit, got.match_b_hit);
      check_field("match_c_hit", want.match_c_hit, got.match_c_hit);
      check_field("capture_hit", want.capture_hit, got.capture_hit);
      check_field("captured_value", want.captured_value, got.captured_value);
      check_field("illegal_mode", want.illegal_mode, got.illegal_mode);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_mode;
  logic [9:0]  in_prescale_count;
  logic        in_ext_clock_pin;
  logic        in_capture_pin;
  logic [15:0] in_write_value;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_count_value;
  logic        out_counting_up;
  logic        out_wave_a;
  logic        out_wave_b;
  logic        out_wave_c;
  logic        out_overflow_hit;
  logic        out_match_a_hit;
  logic        out_match_b_hit;
  logic        out_match_c_hit;
  logic        out_capture_hit;
  logic [15:0] out_captured_value;
  logic        out_illegal_mode;

  timer_scoreboard sb;

  // Flow-control knobs, set by the stimulus process phase by phase.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // A long receiver hold-off is requested by bumping stalls_asked; the
  // receiver process counts the hold-off itself and bumps stalls_served.
  int stalls_asked  = 0;
  int stalls_served = 0;
  int rx_hold       = 0;
  // Slowly varying capture pin level, so that the noise canceller sees
  // stable stretches as well as short glitches.
  logic icp_level = 1'b0;

  pwm_timer_16bit_three_compare_capture dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: random back-pressure, with the odd long hold-off on request so
  // that the result buffer fills and in_ready falls.
  always @(posedge clk) begin
    if (stalls_served != stalls_asked) begin
      stalls_served = stalls_served + 1;
      rx_hold = LONG_HOLD;
    end
    if (rx_hold > 0) begin
      rx_hold = rx_hold - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= $urandom_range(0, 99) >= recv_idle_pct;
    end
  end

  // Monitor: both channels are sampled at the clock edge, before any of the
  // edge's own updates land. The result is checked before the input is
  // noted, so that a spurious result can never match a prediction made at
  // the same edge.
  always @(posedge clk) begin : watch
    ptc_result_t got;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = {out_count_value, out_counting_up, out_wave_a, out_wave_b, out_wave_c,
               out_overflow_hit, out_match_a_hit, out_match_b_hit, out_match_c_hit,
               out_capture_hit, out_captured_value, out_illegal_mode};
        sb.check_result(got);
      end
      if (in_valid && in_ready)
        sb.advance_timer({in_mode, in_prescale_count, in_ext_clock_pin,
                          in_capture_pin, in_write_value});
    end
  end

  function automatic timer_item_t pack_item(logic [1:0] kind, logic [9:0] pre,
                                            logic ext, logic icp, logic [15:0] val);
    timer_item_t it;
    it = {kind, pre, ext, icp, val};
    return it;
  endfunction

  // Random transaction. Most are ticks; counter writes land near the
  // interesting points (top, a compare value, the capture register, either
  // end of the range) so that matches, reloads and turnarounds come soon.
  function automatic timer_item_t make_item();
    timer_item_t it;
    logic [31:0] r;
    logic [15:0] aim;
    logic [15:0] off;
    int          pick;
    r = $urandom;
    it.kind = KIND_TICK;
    it.prescale = r[9:0];
    it.ext_pin = r[10];
    it.value = r[31:16];
    off = {13'd0, r[13:11]};
    // Bias the prescaler count towards the divider taps.
    case ($urandom_range(0, 7))
      0: it.prescale = '0;
      1: it.prescale[7:0] = '0;
      2: it.prescale[5:0] = '0;
      3: it.prescale[2:0] = '0;
      default: ;
    endcase
    if ($urandom_range(0, 5) == 0) icp_level = ~icp_level;
    it.cap_pin = icp_level ^ ($urandom_range(0, 19) == 0);

    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      it.kind = KIND_WR_COUNT;
      case ($urandom_range(0, 5))
        0: aim = sb.counter_top();
        1: aim = sb.cmp[$urandom_range(0, 2)];
        2: aim = 16'h0000;
        3: aim = 16'hFFFF;
        4: aim = sb.icr;
        default: aim = r[31:16];
      endcase
      it.value = r[14] ? aim + off : aim - off;
    end else if (pick < 11) begin
      // About half are short capture values, so that capture-as-top periods are brief.
      it.kind = KIND_WR_CAPT;
      it.value = r[15] ? {7'd0, r[24:16]} : r[31:16];
    end else if (pick < 13) begin
      it.kind = KIND_UNUSED;
    end
    return it;
  endfunction

  // Offers one transaction, after an optional random gap, and returns at the
  // edge that accepts it. in_valid is left high for a following transaction.
  task automatic offer(timer_item_t it);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_mode <= it.kind;
    in_prescale_count <= it.prescale;
    in_ext_clock_pin <= it.ext_pin;
    in_capture_pin <= it.cap_pin;
    in_write_value <= it.value;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops offering and waits until every predicted result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.due_results.size() != 0);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
  endtask

  // Writes the whole register set; only ever called with the timer idle.
  task automatic load_config(logic [3:0] wm, logic [2:0] cs, logic [5:0] om,
                             logic [15:0] ca, logic [15:0] cb, logic [15:0] cc,
                             logic nc, logic ce);
    write_reg(REG_WAVE_MODE, {12'd0, wm});
    write_reg(REG_CLOCK_SEL, {13'd0, cs});
    write_reg(REG_OUTPUT_MODES, {10'd0, om});
    write_reg(REG_COMPARE_A, ca);
    write_reg(REG_COMPARE_B, cb);
    write_reg(REG_COMPARE_C, cc);
    write_reg(REG_NOISE_CANCEL, {15'd0, nc});
    write_reg(REG_CAPTURE_EDGE, {15'd0, ce});
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [31:0] r;
    logic [4:0]  p;
    logic [3:0]  wm;
    logic [2:0]  cs;
    logic [5:0]  om;
    logic [15:0] cv [3];

    sb = new();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_mode <= KIND_TICK;
    in_prescale_count <= '0;
    in_ext_clock_pin <= 1'b0;
    in_capture_pin <= 1'b0;
    in_write_value <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_WAVE_MODE;
    cfg_data <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 11;
    recv_idle_pct = 86;

    // Directed, normal mode: compare matches with toggle, clear and set,
    // a rising capture edge, overflow at the end of the range, both write
    // kinds at the extremes, the unused kind, and a falling capture edge
    // that is accepted but ignored.
    load_config(WM_NORMAL, CS_DIV1, {OM_TOGGLE, OM_CLEAR, OM_SET},
                16'd2, 16'd3, 16'hFFFF, 1'b0, 1'b1);
    offer(pack_item(KIND_TICK, 10'd0, 1'b0, 1'b0, 16'h0000));
    offer(pack_item(KIND_TICK, 10'h3FF, 1'b1, 1'b1, 16'h0000));
    offer(pack_item(KIND_TICK, 10'd1, 1'b0, 1'b1, 16'h0000));
    offer(pack_item(KIND_WR_COUNT, 10'd0, 1'b0, 1'b1, 16'hFFFE));
    offer(pack_item(KIND_TICK, 10'd0, 1'b0, 1'b1, 16'h0000));
    offer(pack_item(KIND_WR_CAPT, 10'd0, 1'b0, 1'b1, 16'hFFFF));
    offer(pack_item(KIND_WR_CAPT, 10'd0, 1'b0, 1'b1, 16'h0000));
    offer(pack_item(KIND_UNUSED, 10'h3FF, 1'b1, 1'b0, 16'hFFFF));
    offer(pack_item(KIND_TICK, 10'd0, 1'b0, 1'b0, 16'h0000));
    offer(pack_item(KIND_WR_COUNT, 10'd0, 1'b0, 1'b0, 16'h0000));
    offer(pack_item(KIND_TICK, 10'h3FF, 1'b0, 1'b0, 16'hFFFF));
    drain();

    // Directed, 8-bit fast PWM on rising external edges with the noise
    // canceller on: reload at top with the pin reset, then a changed pin
    // that only counts on its fourth differing sample, including a sample
    // where the pin returns to its accepted level in between.
    load_config(WM_FAST8, CS_EXT_RISE, {OM_SET, OM_CLEAR, OM_TOGGLE},
                16'h00FE, 16'h0000, 16'h00FF, 1'b1, 1'b0);
    offer(pack_item(KIND_WR_COUNT, 10'd0, 1'b0, 1'b0, 16'h00FD));
    offer(pack_item(KIND_TICK, 10'd5, 1'b1, 1'b1, 16'h0000));
    offer(pack_item(KIND_TICK, 10'd5, 1'b0, 1'b1, 16'h0000));
    offer(pack_item(KIND_TICK, 10'd5, 1'b1, 1'b1, 16'h0000));
    offer(pack_item(KIND_TICK, 10'd5, 1'b1, 1'b1, 16'h0000));
    offer(pack_item(KIND_TICK, 10'd5, 1'b0, 1'b0, 16'h0000));
    offer(pack_item(KIND_TICK, 10'd5, 1'b1, 1'b1, 16'h0000));
    offer(pack_item(KIND_TICK, 10'd5, 1'b0, 1'b0, 16'h0000));
    offer(pack_item(KIND_TICK, 10'd5, 1'b0, 1'b0, 16'h0000));
    offer(pack_item(KIND_TICK, 10'd5, 1'b0, 1'b0, 16'h0000));

    // Random phases. The first sixteen walk through every waveform mode,
    // mostly clocked on every tick; the last eight walk through every clock
    // source. Flow control moves from a slow receiver to a slow sender and
    // finally to none at all.
    for (p = 0; p < PHASES; p++) begin
      send_idle_pct = (p < 8) ? 11 : (p < 16) ? 86 : 0;
      recv_idle_pct = (p < 8) ? 86 : (p < 16) ? 11 : 0;
      drain();

      r = $urandom;
      wm = (p < 16) ? p[3:0] : r[3:0];
      if (p >= 16) cs = p[2:0];
      else cs = (p[1:0] == 2'd3) ? r[6:4] : CS_DIV1;
      om = (p == 0) ? 6'd0 : (p == 1) ? 6'h3F : r[12:7];
      for (int ch = 0; ch < 3; ch++) begin
        r = $urandom;
        if (p == 1) cv[ch] = 16'hFFFF;
        else if (p == 2) cv[ch] = 16'h0000;
        else if (r[17:16] == 2'd0) cv[ch] = r[15:0];
        else if (r[17:16] == 2'd1) cv[ch] = {6'd0, r[9:0]};
        else cv[ch] = {10'd0, r[5:0]};
      end
      r = $urandom;
      load_config(wm, cs, om, cv[0], cv[1], cv[2], r[0], r[1]);

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // A long receiver hold-off while the sender keeps going flat out.
        if (p == 18 && n == 10) stalls_asked = stalls_asked + 1;
        // The sender stops once until every outstanding result is back.
        if (p == 10 && n == 40) drain();
        offer(make_item());
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #4000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/ptc_pkg.sv
rtl/core/ptc_tick_gen.sv
rtl/core/ptc_capture.sv
rtl/core/ptc_core.sv
rtl/core/ptc_out_buf.sv
rtl/core/pwm_timer_16bit_three_compare_capture.sv
tb/tb.sv
